FILE: hw/rtl/tdmc_pkg.sv
// Shared types and constants of the two-level direct-mapped cache core.
`default_nettype none
package tdmc_pkg;

	// configuration registers
	localparam int NUM_REGS = 6;
	localparam int CFG_W    = 10;
	localparam int IDX_W    = 3;

	// register indexes, also used as cost selectors
	localparam logic [IDX_W-1:0] REG_L1_RD  = 3'd0;
	localparam logic [IDX_W-1:0] REG_L1_WR  = 3'd1;
	localparam logic [IDX_W-1:0] REG_L2_RD  = 3'd2;
	localparam logic [IDX_W-1:0] REG_L2_WR  = 3'd3;
	localparam logic [IDX_W-1:0] REG_MEM_RD = 3'd4;
	localparam logic [IDX_W-1:0] REG_MEM_WR = 3'd5;

	// reset values of the cost registers
	localparam logic [CFG_W-1:0] RST_L1_RD  = 10'd1;
	localparam logic [CFG_W-1:0] RST_L1_WR  = 10'd1;
	localparam logic [CFG_W-1:0] RST_L2_RD  = 10'd10;
	localparam logic [CFG_W-1:0] RST_L2_WR  = 10'd10;
	localparam logic [CFG_W-1:0] RST_MEM_RD = 10'd100;
	localparam logic [CFG_W-1:0] RST_MEM_WR = 10'd100;

	// result widths
	localparam int SPENT_W = 14;
	localparam int ACC_W   = 13;
	localparam int TOT_W   = 32;
	localparam int WORD_W  = 32;

	// line transfer kinds
	typedef logic [1:0] xfer_t;
	localparam xfer_t XF_L2_TO_MEM = 2'd0;
	localparam xfer_t XF_MEM_TO_L2 = 2'd1;
	localparam xfer_t XF_L1_TO_L2  = 2'd2;
	localparam xfer_t XF_L2_TO_L1  = 2'd3;

	// request to the cost accumulator
	typedef struct packed {
		logic             clr;
		logic             add;
		logic             commit;
		logic [IDX_W-1:0] sel;
	} acc_op_t;

endpackage
`default_nettype wire

FILE: hw/rtl/tdmc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module tdmc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] waddr,
	input  wire [WIDTH-1:0]         wdata,
	input  wire [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

FILE: hw/rtl/tdmc_acc.sv
// Cost registers and the shared adder that sums access and elapsed cycles.
`default_nettype none
module tdmc_acc (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cfg_we,
	input  wire [tdmc_pkg::IDX_W-1:0]    cfg_index,
	input  wire [tdmc_pkg::CFG_W-1:0]    cfg_wdata,
	input  tdmc_pkg::acc_op_t            op,
	output logic [tdmc_pkg::SPENT_W-1:0] spent,
	output logic [tdmc_pkg::TOT_W-1:0]   elapsed
);
	import tdmc_pkg::*;

	logic [CFG_W-1:0] cfg_q [NUM_REGS];
	logic [CFG_W-1:0] cost;
	logic [TOT_W-1:0] opa, opb, sum;

	// register writes, out-of-range indexes dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q[REG_L1_RD]  <= RST_L1_RD;
			cfg_q[REG_L1_WR]  <= RST_L1_WR;
			cfg_q[REG_L2_RD]  <= RST_L2_RD;
			cfg_q[REG_L2_WR]  <= RST_L2_WR;
			cfg_q[REG_MEM_RD] <= RST_MEM_RD;
			cfg_q[REG_MEM_WR] <= RST_MEM_WR;
		end else if (cfg_we && ({29'd0, cfg_index} < NUM_REGS)) begin
			cfg_q[cfg_index] <= cfg_wdata;
		end
	end

	// cost selection
	always_comb begin
		unique case (op.sel)
			REG_L1_RD:  cost = cfg_q[REG_L1_RD];
			REG_L1_WR:  cost = cfg_q[REG_L1_WR];
			REG_L2_RD:  cost = cfg_q[REG_L2_RD];
			REG_L2_WR:  cost = cfg_q[REG_L2_WR];
			REG_MEM_RD: cost = cfg_q[REG_MEM_RD];
			REG_MEM_WR: cost = cfg_q[REG_MEM_WR];
			default:    cost = '0;
		endcase
	end

	// one adder: access sum, or elapsed plus access sum on commit
	assign opa = op.commit ? elapsed : {{(TOT_W-SPENT_W){1'b0}}, spent};
	assign opb = op.commit ? {{(TOT_W-SPENT_W){1'b0}}, spent}
	                       : {{(TOT_W-CFG_W){1'b0}}, cost};
	assign sum = opa + opb;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spent   <= '0;
			elapsed <= '0;
		end else if (op.clr) begin
			spent <= '0;
		end else if (op.commit) begin
			elapsed <= sum;
		end else if (op.add) begin
			spent <= sum[SPENT_W-1:0];
		end
	end
endmodule
`default_nettype wire

FILE: hw/rtl/two_level_direct_mapped_cache_core.sv
// Top level: sequencer, tag stores, line stores and backing memory of the cache.
`default_nettype none
// Word read/write through a direct-mapped write-back L1, a direct-mapped
// write-back L2 and a backing memory. After reset a clearing pass zeroes the
// backing memory and both tag stores, one word a cycle; busy is high meanwhile.
// A request is taken when start is high and busy low; busy then stays high
// until the result is shown for one cycle with done. On an L1 hit the
// sequencer goes through S_L1M, S_L1C, S_WORD, S_RDW (reads only), S_CMT and
// S_OUT. Each line move runs through one shared copy engine, one word per
// cycle, and every cost is summed by one shared adder; a worst-case miss,
// with a dirty L1 victim and two dirty L2 victims, moves six lines.
module two_level_direct_mapped_cache_core #(
	parameter int L1_LINES      = 256,
	parameter int L2_LINES      = 512,
	parameter int LINE_BYTES    = 64,
	parameter int WORD_BYTES    = 4,
	parameter int MEM_ADDR_BITS = 20
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	output logic                         busy,
	input  wire                          command,
	input  wire [MEM_ADDR_BITS-1:0]      byte_address,
	input  wire [31:0]                   write_word,
	output logic                         done,
	output logic [31:0]                  read_word,
	output logic                         l1_hit,
	output logic                         l2_hit,
	output logic [tdmc_pkg::ACC_W-1:0]   access_cycles,
	output logic [tdmc_pkg::TOT_W-1:0]   total_cycles,
	input  wire                          cfg_we,
	input  wire [tdmc_pkg::IDX_W-1:0]    cfg_index,
	input  wire [tdmc_pkg::CFG_W-1:0]    cfg_wdata
);
	import tdmc_pkg::*;

	localparam int WPL    = LINE_BYTES / WORD_BYTES;
	localparam int OFFB   = $clog2(LINE_BYTES);
	localparam int BYTB   = $clog2(WORD_BYTES);
	localparam int WB     = OFFB - BYTB;
	localparam int LB     = MEM_ADDR_BITS - OFFB;
	localparam int L1IB   = $clog2(L1_LINES);
	localparam int L2IB   = $clog2(L2_LINES);
	localparam int T1     = LB - L1IB;
	localparam int T2     = LB - L2IB;
	localparam int MA     = LB + WB;
	localparam int MEM_WORDS = 1 << MA;
	localparam int M1W    = T1 + 2;
	localparam int M2W    = T2 + 2;
	localparam int CLR_A  = (MEM_WORDS > L2_LINES) ? MEM_WORDS : L2_LINES;
	localparam int CLR_N  = (CLR_A > L1_LINES) ? CLR_A : L1_LINES;
	localparam int CB     = $clog2(CLR_N);

	// sequencer codes
	localparam logic [3:0] S_CLR  = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_L1M  = 4'd2;
	localparam logic [3:0] S_L1C  = 4'd3;
	localparam logic [3:0] S_L2M  = 4'd4;
	localparam logic [3:0] S_L2C  = 4'd5;
	localparam logic [3:0] S_RES  = 4'd6;
	localparam logic [3:0] S_CPY  = 4'd7;
	localparam logic [3:0] S_WORD = 4'd8;
	localparam logic [3:0] S_RDW  = 4'd9;
	localparam logic [3:0] S_CMT  = 4'd10;
	localparam logic [3:0] S_OUT  = 4'd11;

	logic [3:0]         state_q;
	logic [CB-1:0]      clr_q;
	logic               cmd_q;
	logic [LB-1:0]      line_q;
	logic [WB-1:0]      offw_q;
	logic [31:0]        wdata_q;
	logic [LB-1:0]      l2line_q;
	logic [LB-1:0]      memline_q;
	logic               fill_q;
	xfer_t              xf_q;
	logic [WB:0]        cnt_q;
	logic               wv_s1;
	logic [WB-1:0]      ww_s1;
	logic [31:0]        rd_q;
	logic               l1hit_q, l2hit_q;

	logic [L1IB-1:0]    idx1;
	logic [T1-1:0]      tag1;
	logic [L2IB-1:0]    idx2;
	logic [T2-1:0]      tag2;
	logic [WB-1:0]      rw;
	logic               cpy_end, clr_end;

	// stores
	logic               m1_we, m2_we, d1_we, d2_we, bm_we;
	logic [L1IB-1:0]    m1_addr;
	logic [L2IB-1:0]    m2_addr;
	logic [M1W-1:0]     m1_wd, m1_rd;
	logic [M2W-1:0]     m2_wd, m2_rd;
	logic [L1IB+WB-1:0] d1_wa, d1_ra;
	logic [L2IB+WB-1:0] d2_wa, d2_ra;
	logic [MA-1:0]      bm_wa, bm_ra;
	logic [31:0]        d1_wd, d1_rd, d2_wd, d2_rd, bm_wd, bm_rd;
	logic [31:0]        src;

	acc_op_t                op;
	logic [SPENT_W-1:0]     spent;
	logic [TOT_W-1:0]       elapsed;

	assign idx1    = line_q[L1IB-1:0];
	assign tag1    = line_q[LB-1:L1IB];
	assign idx2    = l2line_q[L2IB-1:0];
	assign tag2    = l2line_q[LB-1:L2IB];
	assign rw      = cnt_q[WB-1:0];
	assign cpy_end = (state_q == S_CPY) && (cnt_q == (WB+1)'(WPL));
	assign clr_end = ({1'b0, clr_q} == (CB+1)'(CLR_N - 1));
	assign busy    = (state_q != S_IDLE);

	// copy source by transfer kind
	always_comb begin
		unique case (xf_q)
			XF_L2_TO_MEM: src = d2_rd;
			XF_MEM_TO_L2: src = bm_rd;
			XF_L1_TO_L2:  src = d1_rd;
			XF_L2_TO_L1:  src = d2_rd;
			default:      src = d2_rd;
		endcase
	end

	// store addressing and write strobes
	always_comb begin
		m1_addr = (state_q == S_CLR) ? clr_q[L1IB-1:0] : idx1;
		m2_addr = (state_q == S_CLR) ? clr_q[L2IB-1:0] : idx2;
		m1_we   = 1'b0;
		m1_wd   = '0;
		m2_we   = 1'b0;
		m2_wd   = '0;
		if (state_q == S_CLR) begin
			m1_we = ({1'b0, clr_q} < (CB+1)'(L1_LINES));
			m2_we = ({1'b0, clr_q} < (CB+1)'(L2_LINES));
		end else if (cpy_end && xf_q == XF_L2_TO_L1) begin
			m1_we = 1'b1;
			m1_wd = {2'b10, tag1};
		end else if (cpy_end && xf_q == XF_MEM_TO_L2) begin
			m2_we = 1'b1;
			m2_wd = {2'b10, tag2};
		end else if (cpy_end && xf_q == XF_L1_TO_L2) begin
			m2_we = 1'b1;
			m2_wd = {2'b11, tag2};
		end
		if (state_q == S_WORD && cmd_q) begin
			m1_we = 1'b1;
			m1_wd = {2'b11, tag1};
		end

		d1_ra = {idx1, (state_q == S_WORD) ? offw_q : rw};
		d2_ra = {idx2, rw};
		bm_ra = {memline_q, rw};
		d1_wa = {idx1, (state_q == S_WORD) ? offw_q : ww_s1};
		d2_wa = {idx2, ww_s1};
		bm_wa = (state_q == S_CLR) ? clr_q[MA-1:0] : {memline_q, ww_s1};
		d1_wd = (state_q == S_WORD) ? wdata_q : src;
		d2_wd = src;
		bm_wd = (state_q == S_CLR) ? '0 : src;

		d1_we = ((state_q == S_CPY) && wv_s1 && xf_q == XF_L2_TO_L1)
		        || ((state_q == S_WORD) && cmd_q);
		d2_we = (state_q == S_CPY) && wv_s1
		        && (xf_q == XF_MEM_TO_L2 || xf_q == XF_L1_TO_L2);
		bm_we = ((state_q == S_CPY) && wv_s1 && xf_q == XF_L2_TO_MEM)
		        || ((state_q == S_CLR) && ({1'b0, clr_q} < (CB+1)'(MEM_WORDS)));
	end

	// cost requests
	always_comb begin
		op        = '0;
		op.sel    = REG_L1_RD;
		if (state_q == S_IDLE) begin
			op.clr = start;
		end else if (state_q == S_CMT) begin
			op.commit = 1'b1;
		end else if (state_q == S_WORD) begin
			op.add = 1'b1;
			op.sel = cmd_q ? REG_L1_WR : REG_L1_RD;
		end else if (cpy_end) begin
			op.add = 1'b1;
			unique case (xf_q)
				XF_L2_TO_MEM: op.sel = REG_MEM_WR;
				XF_MEM_TO_L2: op.sel = REG_MEM_RD;
				XF_L1_TO_L2:  op.sel = REG_L2_WR;
				XF_L2_TO_L1:  op.sel = REG_L2_RD;
				default:      op.sel = REG_L2_RD;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q   <= '0;
			cnt_q   <= '0;
			wv_s1   <= 1'b0;
			fill_q  <= 1'b0;
			xf_q    <= XF_L2_TO_MEM;
		end else begin
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_end) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						state_q <= S_L1M;
					end
				end
				S_L1M: state_q <= S_L1C;
				S_L1C: begin
					if (m1_rd[M1W-1] && m1_rd[T1-1:0] == tag1) begin
						state_q <= S_WORD;
					end else if (m1_rd[M1W-1] && m1_rd[M1W-2]) begin
						fill_q  <= 1'b0;
						state_q <= S_L2M;
					end else begin
						fill_q  <= 1'b1;
						state_q <= S_L2M;
					end
				end
				S_L2M: state_q <= S_L2C;
				S_L2C: begin
					cnt_q <= '0;
					wv_s1 <= 1'b0;
					if (m2_rd[M2W-1] && m2_rd[T2-1:0] == tag2) begin
						state_q <= S_RES;
					end else if (m2_rd[M2W-1] && m2_rd[M2W-2]) begin
						xf_q    <= XF_L2_TO_MEM;
						state_q <= S_CPY;
					end else begin
						xf_q    <= XF_MEM_TO_L2;
						state_q <= S_CPY;
					end
				end
				S_RES: begin
					cnt_q   <= '0;
					wv_s1   <= 1'b0;
					xf_q    <= fill_q ? XF_L2_TO_L1 : XF_L1_TO_L2;
					state_q <= S_CPY;
				end
				S_CPY: begin
					if (cpy_end) begin
						cnt_q <= '0;
						wv_s1 <= 1'b0;
						unique case (xf_q)
							XF_L2_TO_MEM: xf_q <= XF_MEM_TO_L2;
							XF_MEM_TO_L2: state_q <= S_RES;
							XF_L1_TO_L2: begin
								fill_q  <= 1'b1;
								state_q <= S_L2M;
							end
							XF_L2_TO_L1: state_q <= S_WORD;
							default:     state_q <= S_WORD;
						endcase
					end else begin
						cnt_q <= cnt_q + 1'b1;
						wv_s1 <= 1'b1;
					end
				end
				S_WORD: state_q <= cmd_q ? S_CMT : S_RDW;
				S_RDW:  state_q <= S_CMT;
				S_CMT:  state_q <= S_OUT;
				S_OUT:  state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// request fields, line addresses and flags
	always_ff @(posedge clk) begin
		ww_s1 <= rw;
		if (state_q == S_IDLE && start) begin
			cmd_q   <= command;
			line_q  <= byte_address[MEM_ADDR_BITS-1:OFFB];
			offw_q  <= byte_address[OFFB-1:BYTB];
			wdata_q <= write_word;
			rd_q    <= '0;
			l2hit_q <= 1'b0;
		end
		if (state_q == S_L1C) begin
			l1hit_q  <= m1_rd[M1W-1] && m1_rd[T1-1:0] == tag1;
			l2line_q <= (m1_rd[M1W-1] && m1_rd[M1W-2]) ? {m1_rd[T1-1:0], idx1} : line_q;
		end
		if (cpy_end && xf_q == XF_L1_TO_L2) begin
			l2line_q <= line_q;
		end
		if (state_q == S_L2C) begin
			if (fill_q) begin
				l2hit_q <= m2_rd[M2W-1] && m2_rd[T2-1:0] == tag2;
			end
			memline_q <= (m2_rd[M2W-1] && m2_rd[M2W-2]) ? {m2_rd[T2-1:0], idx2}
			                                              : l2line_q;
		end
		if (cpy_end && xf_q == XF_L2_TO_MEM) begin
			memline_q <= l2line_q;
		end
		if (state_q == S_RDW) begin
			rd_q <= d1_rd;
		end
	end

	// result
	assign done          = (state_q == S_OUT);
	assign read_word     = rd_q;
	assign l1_hit        = l1hit_q;
	assign l2_hit        = l2hit_q;
	assign access_cycles = spent[ACC_W-1:0];
	assign total_cycles  = elapsed;

	tdmc_acc u_acc (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata), .op(op), .spent(spent), .elapsed(elapsed)
	);

	tdmc_ram #(.WIDTH(M1W), .DEPTH(L1_LINES)) u_l1_meta (
		.clk(clk), .we(m1_we), .waddr(m1_addr), .wdata(m1_wd),
		.raddr(m1_addr), .rdata(m1_rd)
	);

	tdmc_ram #(.WIDTH(M2W), .DEPTH(L2_LINES)) u_l2_meta (
		.clk(clk), .we(m2_we), .waddr(m2_addr), .wdata(m2_wd),
		.raddr(m2_addr), .rdata(m2_rd)
	);

	tdmc_ram #(.WIDTH(32), .DEPTH(L1_LINES * WPL)) u_l1_data (
		.clk(clk), .we(d1_we), .waddr(d1_wa), .wdata(d1_wd),
		.raddr(d1_ra), .rdata(d1_rd)
	);

	tdmc_ram #(.WIDTH(32), .DEPTH(L2_LINES * WPL)) u_l2_data (
		.clk(clk), .we(d2_we), .waddr(d2_wa), .wdata(d2_wd),
		.raddr(d2_ra), .rdata(d2_rd)
	);

	tdmc_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_backing (
		.clk(clk), .we(bm_we), .waddr(bm_wa), .wdata(bm_wd),
		.raddr(bm_ra), .rdata(bm_rd)
	);
endmodule
`default_nettype wire

FILE: tb/sv/tb_two_level_direct_mapped_cache_core.sv
// Testbench of the two-level direct-mapped cache core: random and directed requests, scored.
`default_nettype none
module tb_two_level_direct_mapped_cache_core;
	timeunit 1ns;
	timeprecision 1ps;
	import tdmc_pkg::*;

	localparam int WPL = 16;

	typedef struct {
		logic [31:0]      rd;
		logic             h1;
		logic             h2;
		logic [ACC_W-1:0] acc;
		logic [TOT_W-1:0] tot;
	} cache_result_t;

	// Scoreboard: holds its own copy of both cache levels and of memory
	class cache_scoreboard;
		bit               l1v[256], l1d[256];
		bit [5:0]         l1t[256];
		bit [31:0]        l1w[256][WPL];
		bit               l2v[512], l2d[512];
		bit [4:0]         l2t[512];
		bit [31:0]        l2w[512][WPL];
		bit [31:0]        mem[int];
		bit [CFG_W-1:0]   cost[NUM_REGS];
		bit [31:0]        elapsed;
		int unsigned      spent;
		cache_result_t    pending[$];
		int               errors;
		int               checked;
		int               l1_hits, l2_hits, n_writes;

		function void clear();
			foreach (l1v[i]) begin l1v[i] = 0; l1d[i] = 0; l1t[i] = 0; end
			foreach (l2v[i]) begin l2v[i] = 0; l2d[i] = 0; l2t[i] = 0; end
			mem.delete();
			cost[REG_L1_RD] = RST_L1_RD;
			cost[REG_L1_WR] = RST_L1_WR;
			cost[REG_L2_RD] = RST_L2_RD;
			cost[REG_L2_WR] = RST_L2_WR;
			cost[REG_MEM_RD] = RST_MEM_RD;
			cost[REG_MEM_WR] = RST_MEM_WR;
			elapsed = 0;
		endfunction

		function void set_cost(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
			if (idx < NUM_REGS)
				cost[idx] = val;
		endfunction

		// bring a line into L2, writing back a dirty victim; 1 on hit
		function bit l2_fetch(bit [13:0] line);
			bit [8:0] idx;
			bit [4:0] tg;
			int base;
			idx = line[8:0];
			tg = line[13:9];
			if (l2v[idx] && l2t[idx] == tg)
				return 1;
			if (l2v[idx] && l2d[idx]) begin
				base = {l2t[idx], idx} * WPL;
				for (int w = 0; w < WPL; w++)
					mem[base + w] = l2w[idx][w];
				spent += cost[REG_MEM_WR];
			end
			base = line * WPL;
			for (int w = 0; w < WPL; w++)
				l2w[idx][w] = mem.exists(base + w) ? mem[base + w] : 32'h0;
			spent += cost[REG_MEM_RD];
			l2v[idx] = 1;
			l2d[idx] = 0;
			l2t[idx] = tg;
			return 0;
		endfunction

		function void note_request(logic cmd, logic [19:0] addr, logic [31:0] wd);
			cache_result_t r;
			bit [13:0] line, vline;
			bit [7:0] idx;
			bit [3:0] off;
			bit dummy;
			line = addr[19:6];
			idx = line[7:0];
			off = addr[5:2];
			spent = 0;
			r.rd = 0;
			r.h2 = 0;
			r.h1 = l1v[idx] && l1t[idx] == line[13:8];
			if (!r.h1) begin
				if (l1v[idx] && l1d[idx]) begin
					vline = {l1t[idx], idx};
					dummy = l2_fetch(vline);
					l2w[vline[8:0]] = l1w[idx];
					l2d[vline[8:0]] = 1;
					spent += cost[REG_L2_WR];
				end
				r.h2 = l2_fetch(line);
				l1w[idx] = l2w[line[8:0]];
				spent += cost[REG_L2_RD];
				l1v[idx] = 1;
				l1d[idx] = 0;
				l1t[idx] = line[13:8];
			end
			if (!cmd) begin
				r.rd = l1w[idx][off];
				spent += cost[REG_L1_RD];
			end else begin
				l1w[idx][off] = wd;
				l1d[idx] = 1;
				spent += cost[REG_L1_WR];
				n_writes++;
			end
			elapsed += spent;
			r.acc = spent[ACC_W-1:0];
			r.tot = elapsed;
			l1_hits += r.h1;
			l2_hits += r.h2;
			pending.push_back(r);
		endfunction

		function void report_mismatch(string what, logic [31:0] got, logic [31:0] want);
			errors++;
			$display("MISMATCH result %0d %s: got %h expected %h", checked, what, got, want);
		endfunction

		function void check_result(cache_result_t got);
			cache_result_t want;
			if (pending.size() == 0) begin
				errors++;
				$display("MISMATCH result with no request outstanding");
				return;
			end
			want = pending.pop_front();
			if (got.rd !== want.rd) report_mismatch("read_word", got.rd, want.rd);
			if (got.h1 !== want.h1) report_mismatch("l1_hit", 32'(got.h1), 32'(want.h1));
			if (got.h2 !== want.h2) report_mismatch("l2_hit", 32'(got.h2), 32'(want.h2));
			if (got.acc !== want.acc)
				report_mismatch("access_cycles", 32'(got.acc), 32'(want.acc));
			if (got.tot !== want.tot) report_mismatch("total_cycles", got.tot, want.tot);
			checked++;
		endfunction
	endclass

	logic                 clk = 0;
	logic                 arst_n = 0;
	logic                 start = 0;
	logic                 command = 0;
	logic [19:0]          byte_address = 0;
	logic [31:0]          write_word = 0;
	logic                 cfg_we = 0;
	logic [IDX_W-1:0]     cfg_index = 0;
	logic [CFG_W-1:0]     cfg_wdata = 0;
	wire                  busy, done, l1_hit, l2_hit;
	wire [31:0]           read_word;
	wire [ACC_W-1:0]      access_cycles;
	wire [TOT_W-1:0]      total_cycles;

	cache_scoreboard sb = new();
	bit [5:0] tag_pool[4];
	bit gaps_on = 1;

	two_level_direct_mapped_cache_core uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.command(command), .byte_address(byte_address), .write_word(write_word),
		.done(done), .read_word(read_word), .l1_hit(l1_hit), .l2_hit(l2_hit),
		.access_cycles(access_cycles), .total_cycles(total_cycles),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	// results are checked on the edge that ends the done cycle
	always @(posedge clk) begin
		cache_result_t got;
		if (arst_n && done) begin
			got.rd = read_word;
			got.h1 = l1_hit;
			got.h2 = l2_hit;
			got.acc = access_cycles;
			got.tot = total_cycles;
			sb.check_result(got);
		end
	end

	// one request; called just after a rising edge
	task automatic send_request(logic cmd, logic [19:0] addr, logic [31:0] wd);
		int gap;
		start <= 1;
		command <= cmd;
		byte_address <= addr;
		write_word <= wd;
		do @(posedge clk); while (busy);
		sb.note_request(cmd, addr, wd);
		if (gaps_on && $urandom_range(0, 2) == 0) begin
			gap = $urandom_range(1, 14);
			start <= 0;
			command <= 1'($urandom_range(0, 1));
			byte_address <= 20'($urandom);
			write_word <= $urandom;
			repeat (gap) @(posedge clk);
		end
	endtask

	// quiet the block before touching the cost registers
	task automatic drain();
		start <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	// one register write; the caller drops cfg_we after the last one
	task automatic write_cost(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		sb.set_cost(idx, val);
	endtask

	task automatic set_all_costs(int mode);
		for (int i = 0; i < 8; i++) begin
			case (mode)
				0: write_cost(IDX_W'(i), 10'd0);
				1: write_cost(IDX_W'(i), 10'h3FF);
				default: write_cost(IDX_W'(i), CFG_W'($urandom_range(0, 1023)));
			endcase
		end
		cfg_we <= 0;
	endtask

	function automatic logic [19:0] pick_address();
		if ($urandom_range(0, 9) < 2)
			return 20'($urandom);
		return {tag_pool[$urandom_range(0, 3)], 5'd0, 3'($urandom_range(0, 7)),
			6'($urandom)};
	endfunction

	task automatic random_phase(int n);
		foreach (tag_pool[i]) tag_pool[i] = 6'($urandom);
		for (int i = 0; i < n; i++)
			send_request(1'($urandom_range(0, 1)), pick_address(), $urandom);
	endtask

	initial begin
		#4000000;
		$display("Timeout with %0d results outstanding", sb.pending.size());
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		sb.clear();
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		while (busy) @(posedge clk);

		// directed: extremes, conflicts in both levels, unaligned bytes
		send_request(0, 20'h00000, 32'h0);
		send_request(1, 20'hFFFFF, 32'hFFFFFFFF);
		send_request(0, 20'hFFFFC, 32'h0);
		send_request(1, 20'h00007, 32'hA5A5A5A5);
		send_request(1, 20'h04005, 32'h5A5A5A5A);
		send_request(1, 20'h08006, 32'h12345678);
		send_request(1, 20'h10001, 32'h87654321);
		send_request(0, 20'h00004, 32'hFFFFFFFF);
		send_request(0, 20'h04004, 32'h0);
		send_request(0, 20'h08004, 32'h0);
		send_request(0, 20'h10000, 32'h0);
		send_request(0, 20'hFFFFF, 32'h0);
		send_request(1, 20'h7FFC0, 32'hDEADBEEF);
		send_request(0, 20'h7FFC3, 32'h0);
		drain();

		// cost settings: all zero, all max, then random ones
		set_all_costs(0);
		random_phase(350);
		drain();
		set_all_costs(1);
		random_phase(350);
		drain();
		set_all_costs(2);
		random_phase(350);
		drain();
		set_all_costs(2);
		random_phase(350);
		gaps_on = 0;
		random_phase(350);

		start <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		$display("Checked %0d results: %0d L1 hits, %0d L2 hits, %0d writes, 5 cost settings",
			sb.checked, sb.l1_hits, sb.l2_hits, sb.n_writes);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
`default_nettype wire

FILE: filelist.f
hw/rtl/tdmc_pkg.sv
hw/rtl/tdmc_ram.sv
hw/rtl/tdmc_acc.sv
hw/rtl/two_level_direct_mapped_cache_core.sv
tb/sv/tb_two_level_direct_mapped_cache_core.sv
